// File: src/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg: shared types and constants
// Register indexes, reset values, request codes and the configuration
// bundle of the button debounce / press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  // configuration register width and index width
  localparam int unsigned CFG_W = 24;
  localparam int unsigned IDX_W = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_LONG_PRESS  = 2'd1;
  localparam logic [IDX_W-1:0] REG_CLOSED_HIGH = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 24'd20000;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 24'd1000000;
  localparam logic             CLOSED_HIGH_RST = 1'b0;

  // request type codes
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  // configuration bundle
  typedef struct packed {
    logic [CFG_W-1:0] debounce_us;
    logic [CFG_W-1:0] long_press_us;
    logic             closed_is_high;
  } cfg_t;

endpackage

// File: src/bdpc_in_if.sv
// ----------------------------------------------------------------------------
// bdpc_in_if: input channel
// Valid/ready channel carrying one timestamped pin observation per word.
// ----------------------------------------------------------------------------
interface bdpc_in_if #(
  parameter int unsigned TW = 48
);
  logic          valid;
  logic          ready;
  logic          req_type;
  logic          pin_level;
  logic [TW-1:0] time_us;

  modport source (output valid, output req_type, output pin_level, output time_us,
                  input ready);
  modport sink   (input valid, input req_type, input pin_level, input time_us,
                  output ready);
endinterface

// File: src/bdpc_out_if.sv
// ----------------------------------------------------------------------------
// bdpc_out_if: result channel
// Valid/ready channel carrying one debounce / press result word.
// ----------------------------------------------------------------------------
interface bdpc_out_if #(
  parameter int unsigned TW = 48
);
  logic          valid;
  logic          ready;
  logic          change_valid;
  logic          change_closed;
  logic [TW-1:0] change_time_us;
  logic          short_press;
  logic          long_press;
  logic          held_repeat;
  logic          pressed_now;

  modport source (output valid, output change_valid, output change_closed,
                  output change_time_us, output short_press, output long_press,
                  output held_repeat, output pressed_now, input ready);
  modport sink   (input valid, input change_valid, input change_closed,
                  input change_time_us, input short_press, input long_press,
                  input held_repeat, input pressed_now, output ready);
endinterface

// File: src/button_debounce_press_classifier_top.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top: button debouncer and press classifier
// Input register, single-cycle step logic and output register.
// ----------------------------------------------------------------------------
// Each input word (an edge event or a poll with the live level) yields exactly
// one result word: a debounced change report with the time the level first
// moved away, the short / long / held-repeat press flags, and the current
// debounced closed state. One word is accepted every cycle while the result
// side takes words; a stall on out_o.ready holds both registers. A word
// accepted sits in the input register, passes the step logic and is presented
// from the output register. The tracking state updates in the same cycle a
// word moves between the two registers, which sets the one-word-per-cycle
// rate. Configuration is written through a plain write port; the user must do
// so only while the block is idle, which the block itself does not enforce.
module button_debounce_press_classifier_top #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bdpc_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [bdpc_pkg::CFG_W-1:0] cfg_wdata_i,
  bdpc_in_if.sink                    in_i,
  bdpc_out_if.source                 out_o
);

  localparam int unsigned TW = TIME_BITS;

  bdpc_pkg::cfg_t cfg;

  // input register
  logic          in_v_q;
  logic          type_q;
  logic          level_q;
  logic [TW-1:0] time_q;

  // output register
  logic          out_v_q;
  logic          chg_q, chg_cl_q, short_q, long_q, held_q, press_q;
  logic [TW-1:0] chg_t_q;

  // step results
  logic          chg_d, chg_cl_d, short_d, long_d, held_d, press_d;
  logic [TW-1:0] chg_t_d;

  logic advance;
  assign advance    = in_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !in_v_q || advance;

  bdpc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  bdpc_core #(.TW(TW)) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (advance),
    .cfg_i            (cfg),
    .req_type_i       (type_q),
    .pin_level_i      (level_q),
    .time_us_i        (time_q),
    .change_valid_o   (chg_d),
    .change_closed_o  (chg_cl_d),
    .change_time_us_o (chg_t_d),
    .short_press_o    (short_d),
    .long_press_o     (long_d),
    .held_repeat_o    (held_d),
    .pressed_now_o    (press_d)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_v_q <= in_i.valid;
      end
      if (advance) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // input word capture
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      type_q  <= in_i.req_type;
      level_q <= in_i.pin_level;
      time_q  <= in_i.time_us;
    end
  end

  // result word capture
  always_ff @(posedge clk_i) begin
    if (advance) begin
      chg_q    <= chg_d;
      chg_cl_q <= chg_cl_d;
      chg_t_q  <= chg_t_d;
      short_q  <= short_d;
      long_q   <= long_d;
      held_q   <= held_d;
      press_q  <= press_d;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.change_valid   = chg_q;
  assign out_o.change_closed  = chg_cl_q;
  assign out_o.change_time_us = chg_t_q;
  assign out_o.short_press    = short_q;
  assign out_o.long_press     = long_q;
  assign out_o.held_repeat    = held_q;
  assign out_o.pressed_now    = press_q;

`ifndef ASSERT_OFF
  // edges never raise long-press or held-repeat flags
  a_edge_no_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && type_q == bdpc_pkg::REQ_EDGE) |=> (!long_q && !held_q))
    else $error("long or held flag on an edge word");

  // long-press flags only while debounced closed
  a_long_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (long_q || held_q)) |-> press_q)
    else $error("long or held flag while open");

  // a reported change matches the debounced state after the word
  a_change_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && chg_q) |-> (chg_cl_q == press_q))
    else $error("change report disagrees with debounced state");

  // a short press ends only on a release report
  a_short_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && short_q) |-> (chg_q && !chg_cl_q))
    else $error("short press without release report");
`endif

endmodule

// File: src/bdpc_cfg.sv
// ----------------------------------------------------------------------------
// bdpc_cfg: configuration registers
// Write-only register file for debounce time, long-press time and polarity.
// ----------------------------------------------------------------------------
module bdpc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [bdpc_pkg::IDX_W-1:0]  idx_i,
  input  logic [bdpc_pkg::CFG_W-1:0]  wdata_i,
  output bdpc_pkg::cfg_t              cfg_o
);

  bdpc_pkg::cfg_t cfg_q;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_us    <= bdpc_pkg::DEBOUNCE_RST;
      cfg_q.long_press_us  <= bdpc_pkg::LONG_PRESS_RST;
      cfg_q.closed_is_high <= bdpc_pkg::CLOSED_HIGH_RST;
    end else if (we_i) begin
      case (idx_i)
        bdpc_pkg::REG_DEBOUNCE:    cfg_q.debounce_us    <= wdata_i;
        bdpc_pkg::REG_LONG_PRESS:  cfg_q.long_press_us  <= wdata_i;
        bdpc_pkg::REG_CLOSED_HIGH: cfg_q.closed_is_high <= wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/bdpc_core.sv
// ----------------------------------------------------------------------------
// bdpc_core: debounce and press classification step
// Holds the tracking state and computes one result word per fired item.
// ----------------------------------------------------------------------------
module bdpc_core #(
  parameter int unsigned TW = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  bdpc_pkg::cfg_t cfg_i,
  input  logic           req_type_i,
  input  logic           pin_level_i,
  input  logic [TW-1:0]  time_us_i,
  output logic           change_valid_o,
  output logic           change_closed_o,
  output logic [TW-1:0]  change_time_us_o,
  output logic           short_press_o,
  output logic           long_press_o,
  output logic           held_repeat_o,
  output logic           pressed_now_o
);

  // tracking state
  logic          isr_q, isr_d;
  logic          raw_q, raw_d;
  logic          deb_q, deb_d;
  logic [TW-1:0] let_t_q, let_t_d;
  logic          let_v_q, let_v_d;
  logic [TW-1:0] aw_t_q, aw_t_d;
  logic          aw_v_q, aw_v_d;
  logic [TW-1:0] pm_t_q, pm_t_d;
  logic          pm_v_q, pm_v_d;
  logic          held_q, held_d;

  // now strictly after then, by more than limit
  function automatic logic exceeds(input logic [TW-1:0] now, input logic [TW-1:0] then,
                                   input logic [TW-1:0] limit);
    logic [TW-1:0] diff;
    diff = now - then;
    return (now > then) && (diff > limit);
  endfunction

  logic [TW-1:0] deb_lim, lp_lim;
  assign deb_lim = TW'(cfg_i.debounce_us);
  assign lp_lim  = TW'(cfg_i.long_press_us);

  // one item: raw event, timeout check, report, long-press check
  always_comb begin
    logic          closed;
    logic          is_poll;
    logic          ev;
    logic          rep;
    logic          rep_closed;
    logic [TW-1:0] rep_time;
    logic [TW-1:0] pm_diff;

    closed     = (pin_level_i == cfg_i.closed_is_high);
    is_poll    = (req_type_i == bdpc_pkg::REQ_POLL);
    ev         = 1'b0;
    rep        = 1'b0;
    rep_closed = 1'b0;
    rep_time   = '0;

    isr_d   = isr_q;
    raw_d   = raw_q;
    deb_d   = deb_q;
    let_t_d = let_t_q;
    let_v_d = let_v_q;
    aw_t_d  = aw_t_q;
    aw_v_d  = aw_v_q;
    pm_t_d  = pm_t_q;
    pm_v_d  = pm_v_q;
    held_d  = held_q;

    short_press_o = 1'b0;
    long_press_o  = 1'b0;
    held_repeat_o = 1'b0;

    // edge filter, or poll level mismatch
    if (!is_poll) begin
      if (closed != isr_q) begin
        isr_d = closed;
        ev    = 1'b1;
      end
    end else begin
      ev = (closed != raw_q);
    end

    // raw-level event, dropped when level unchanged or time stale
    if (ev && !(raw_q == closed || (let_v_q && time_us_i <= let_t_q))) begin
      let_t_d = time_us_i;
      let_v_d = 1'b1;
      raw_d   = closed;
      if (closed != deb_q) begin
        aw_t_d = time_us_i;
        aw_v_d = 1'b1;
      end else if (aw_v_q && exceeds(time_us_i, aw_t_q, deb_lim)) begin
        rep        = 1'b1;
        rep_closed = !closed;
        rep_time   = aw_t_q;
        deb_d      = !closed;
        aw_t_d     = time_us_i;
      end
    end

    // poll timeout: level stayed away long enough
    if (is_poll && aw_v_d && (deb_d != raw_d) && exceeds(time_us_i, aw_t_d, deb_lim)) begin
      deb_d      = raw_d;
      rep        = 1'b1;
      rep_closed = raw_d;
      rep_time   = aw_t_d;
    end

    // report a debounced change to the press classifier
    if (rep) begin
      if (rep_closed) begin
        pm_t_d = rep_time;
        pm_v_d = 1'b1;
      end else begin
        if (pm_v_d && !held_d && (rep_time < pm_t_d || (rep_time - pm_t_d) < lp_lim)) begin
          pm_t_d        = rep_time;
          short_press_o = 1'b1;
        end
        held_d = 1'b0;
      end
    end

    // long press and held repeat, polls only
    pm_diff = time_us_i - pm_t_d;
    if (is_poll && deb_d && pm_v_d && time_us_i >= pm_t_d && pm_diff >= lp_lim) begin
      pm_t_d = time_us_i;
      if (!held_d) begin
        held_d       = 1'b1;
        long_press_o = 1'b1;
      end else begin
        held_repeat_o = 1'b1;
      end
    end

    change_valid_o   = rep;
    change_closed_o  = rep_closed;
    change_time_us_o = rep_time;
    pressed_now_o    = deb_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isr_q   <= 1'b0;
      raw_q   <= 1'b0;
      deb_q   <= 1'b0;
      let_v_q <= 1'b0;
      aw_v_q  <= 1'b0;
      pm_v_q  <= 1'b0;
      held_q  <= 1'b0;
    end else if (fire_i) begin
      isr_q   <= isr_d;
      raw_q   <= raw_d;
      deb_q   <= deb_d;
      let_v_q <= let_v_d;
      aw_v_q  <= aw_v_d;
      pm_v_q  <= pm_v_d;
      held_q  <= held_d;
    end
  end

  // timestamps, only read behind their valid bits
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      let_t_q <= let_t_d;
      aw_t_q  <= aw_t_d;
      pm_t_q  <= pm_t_d;
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for button_debounce_press_classifier_top
// Sends edge events and polls with random gaps and stalls the result side at
// random. A local model of the debouncer and press classifier predicts every
// result word, and each word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned TW          = 48;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [TW-1:0] TIME_TOP  = {TW{1'b1}};

  // one result word, in port order
  typedef struct packed {
    logic          chg;
    logic          chg_closed;
    logic [TW-1:0] chg_time;
    logic          short_p;
    logic          long_p;
    logic          held_p;
    logic          pressed;
  } press_res_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [bdpc_pkg::IDX_W-1:0] cfg_idx_i   = '0;
  logic [bdpc_pkg::CFG_W-1:0] cfg_wdata_i = '0;

  bdpc_in_if  #(.TW(TW)) in_if  ();
  bdpc_out_if #(.TW(TW)) out_if ();

  button_debounce_press_classifier_top #(.TIME_BITS(TW)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // clock: 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the configuration registers
  logic [bdpc_pkg::CFG_W-1:0] cfg_debounce = bdpc_pkg::DEBOUNCE_RST;
  logic [bdpc_pkg::CFG_W-1:0] cfg_long     = bdpc_pkg::LONG_PRESS_RST;
  logic                       cfg_high     = bdpc_pkg::CLOSED_HIGH_RST;

  // debouncer / classifier state
  logic          edge_seen_closed = 1'b0;
  logic          level_closed     = 1'b0;
  logic          stable_closed    = 1'b0;
  logic [TW-1:0] last_evt_us      = '0;
  logic          last_evt_ok      = 1'b0;
  logic [TW-1:0] away_us          = '0;
  logic          away_ok          = 1'b0;
  logic [TW-1:0] mark_us          = '0;
  logic          mark_ok          = 1'b0;
  logic          held_on          = 1'b0;
  press_res_t    pred;

  press_res_t press_expect_q[$];
  press_res_t got, want;

  // stimulus and bookkeeping
  logic [TW-1:0] now_us       = '0;
  logic          steady_src   = 1'b0;
  logic          steady_snk   = 1'b0;
  int unsigned   stall_left   = 0;
  int unsigned   words_sent   = 0;
  int unsigned   results_seen = 0;
  int unsigned   mismatches   = 0;
  int unsigned   cycles       = 0;
  int unsigned   n_settings   = 0;
  int unsigned   n_chg = 0, n_short = 0, n_long = 0, n_held = 0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // strictly later and more than lim apart; backwards time counts as zero
  function automatic logic gone_past(input logic [TW-1:0] later,
                                     input logic [TW-1:0] earlier,
                                     input logic [bdpc_pkg::CFG_W-1:0] lim);
    return (later > earlier) && ((later - earlier) > TW'(lim));
  endfunction

  // report a debounced change and run the press classifier
  function automatic void record_change(input logic closed, input logic [TW-1:0] t);
    pred.chg        = 1'b1;
    pred.chg_closed = closed;
    pred.chg_time   = t;
    if (closed) begin
      mark_us = t;
      mark_ok = 1'b1;
    end else begin
      if (mark_ok && !held_on && (t < mark_us || (t - mark_us) < TW'(cfg_long))) begin
        mark_us      = t;
        pred.short_p = 1'b1;
      end
      held_on = 1'b0;
    end
  endfunction

  // raw level event; stale times and unchanged levels are dropped
  function automatic void raw_update(input logic closed, input logic [TW-1:0] t);
    if (level_closed == closed || (last_evt_ok && t <= last_evt_us)) return;
    last_evt_us  = t;
    last_evt_ok  = 1'b1;
    level_closed = closed;
    if (level_closed != stable_closed) begin
      away_us = t;
      away_ok = 1'b1;
    end else if (away_ok && gone_past(t, away_us, cfg_debounce)) begin
      // level came back after a long excursion: the excursion counts
      record_change(!level_closed, away_us);
      stable_closed = !level_closed;
      away_us       = t;
    end
  endfunction

  function automatic void press_predict(input logic rq, input logic lvl,
                                        input logic [TW-1:0] t);
    logic closed;
    closed = (lvl == cfg_high);
    pred   = '0;
    if (rq == bdpc_pkg::REQ_EDGE) begin
      if (closed != edge_seen_closed) begin
        edge_seen_closed = closed;
        raw_update(closed, t);
      end
    end else begin
      if (closed != level_closed) raw_update(closed, t);
      // timeout on the poll
      if (away_ok && stable_closed != level_closed && gone_past(t, away_us, cfg_debounce)) begin
        stable_closed = level_closed;
        record_change(stable_closed, away_us);
      end
      // long press, then held-repeat each further interval
      if (stable_closed && mark_ok && t >= mark_us && (t - mark_us) >= TW'(cfg_long)) begin
        mark_us = t;
        if (!held_on) begin
          held_on     = 1'b1;
          pred.long_p = 1'b1;
        end else begin
          pred.held_p = 1'b1;
        end
      end
    end
    pred.pressed = stable_closed;
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_wait(input logic steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // send one word, then predict its result once accepted
  task automatic send_word(input logic rq, input logic lvl, input logic [TW-1:0] t);
    int unsigned gap;
    gap = pick_wait(steady_src);
    if (gap != 0) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid     = 1'b1;
    in_if.req_type  = rq;
    in_if.pin_level = lvl;
    in_if.time_us   = t;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    press_predict(rq, lvl, t);
    press_expect_q.push_back(pred);
    words_sent++;
  endtask

  task automatic send_state(input logic rq, input logic closed);
    send_word(rq, closed ? cfg_high : ~cfg_high, now_us);
  endtask

  task automatic step_time(input int unsigned dt);
    now_us = now_us + TW'(dt);
  endtask

  // stop sending and wait until every result word is back
  task automatic settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (press_expect_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bdpc_pkg::IDX_W-1:0] idx,
                           input logic [bdpc_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      bdpc_pkg::REG_DEBOUNCE:    cfg_debounce = data;
      bdpc_pkg::REG_LONG_PRESS:  cfg_long     = data;
      bdpc_pkg::REG_CLOSED_HIGH: cfg_high     = data[0];
      default: ;
    endcase
  endtask

  // result side: random stalls with quiet stretches
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else begin
      out_if.ready = 1'b1;
      stall_left   = pick_wait(steady_snk);
    end
    if ($urandom_range(0, 299) == 0) steady_snk = ~steady_snk;
  end

  function automatic string res_text(input press_res_t r);
    return $sformatf("chg=%b closed=%b at=%0d short=%b long=%b held=%b pressed=%b",
                     r.chg, r.chg_closed, r.chg_time, r.short_p, r.long_p, r.held_p,
                     r.pressed);
  endfunction

  // check each result word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.change_valid, out_if.change_closed, out_if.change_time_us,
             out_if.short_press, out_if.long_press, out_if.held_repeat,
             out_if.pressed_now};
      results_seen++;
      if (press_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %s", res_text(got));
      end else begin
        want = press_expect_q.pop_front();
        n_chg   += want.chg;
        n_short += want.short_p;
        n_long  += want.long_p;
        n_held  += want.held_p;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d expected %s", results_seen, res_text(want));
            $display("result %0d actual   %s", results_seen, res_text(got));
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               press_expect_q.size());
      $display("button_debounce_press_classifier_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // one press with contact bounce, a hold of some class, and a bouncy release
  task automatic press_cycle();
    int unsigned d, l, k, nb, np, mode;
    logic        via_edge;
    d        = 32'(cfg_debounce);
    l        = 32'(cfg_long);
    via_edge = 1'($urandom_range(0, 1));
    steady_src = ($urandom_range(0, 4) == 0);
    nb = $urandom_range(0, 3);
    for (k = 0; k < nb; k++) begin
      step_time($urandom_range(1, d / 4 + 1));
      send_state(via_edge ? bdpc_pkg::REQ_EDGE : bdpc_pkg::REQ_POLL, (k % 2) == 0);
    end
    step_time($urandom_range(1, d / 4 + 1));
    send_state(via_edge ? bdpc_pkg::REQ_EDGE : bdpc_pkg::REQ_POLL, 1'b1);
    // first poll right around the debounce boundary
    step_time(d + $urandom_range(0, 2));
    send_state(bdpc_pkg::REQ_POLL, 1'b1);
    // hold: short, near the long-press threshold, or long with repeats
    mode = $urandom_range(0, 2);
    np   = $urandom_range(1, 5);
    for (k = 0; k < np; k++) begin
      case (mode)
        0:       step_time($urandom_range(0, l / (2 * np)));
        1:       step_time(l - 1 + $urandom_range(0, 2));
        default: step_time($urandom_range(0, 2 * l));
      endcase
      send_state(bdpc_pkg::REQ_POLL, 1'b1);
    end
    nb = $urandom_range(0, 3);
    for (k = 0; k < nb; k++) begin
      step_time($urandom_range(1, d / 4 + 1));
      send_state(via_edge ? bdpc_pkg::REQ_EDGE : bdpc_pkg::REQ_POLL, (k % 2) == 1);
    end
    step_time($urandom_range(1, d / 4 + 1));
    send_state(via_edge ? bdpc_pkg::REQ_EDGE : bdpc_pkg::REQ_POLL, 1'b0);
    step_time(d + $urandom_range(0, 2));
    send_state(bdpc_pkg::REQ_POLL, 1'b0);
    if ($urandom_range(0, 1) == 1) begin
      step_time($urandom_range(0, d + 1));
      send_state(bdpc_pkg::REQ_POLL, 1'b0);
    end
  endtask

  // random words: forward, stale, backwards and far-jump timestamps
  task automatic noise_burst();
    int unsigned   n, k, r, back, span;
    logic [TW-1:0] t;
    n    = $urandom_range(1, 5);
    span = 32'(cfg_debounce) + 32'(cfg_long);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        step_time($urandom_range(0, span));
        t = now_us;
      end else if (r < 60) begin
        t = now_us;
      end else if (r < 80) begin
        back = $urandom_range(0, 1000000);
        t    = (now_us > TW'(back)) ? now_us - TW'(back) : '0;
      end else begin
        if (now_us < 48'h4000_0000_0000) begin
          now_us = now_us + (TW'($urandom) << $urandom_range(0, 12));
        end
        t = now_us;
      end
      send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), t);
    end
  endtask

  // one configuration setting, then well-formed presses mixed with noise
  task automatic run_phase(input logic [bdpc_pkg::CFG_W-1:0] deb,
                           input logic [bdpc_pkg::CFG_W-1:0] lng,
                           input logic high, input int unsigned n);
    int unsigned goal;
    settle();
    write_reg(bdpc_pkg::REG_DEBOUNCE, deb);
    write_reg(bdpc_pkg::REG_LONG_PRESS, lng);
    write_reg(bdpc_pkg::REG_CLOSED_HIGH, {{(bdpc_pkg::CFG_W-1){1'b0}}, high});
    n_settings++;
    goal = words_sent + n;
    while (words_sent < goal) begin
      if ($urandom_range(0, 9) < 7) press_cycle();
      else noise_burst();
    end
  endtask

  // hand-picked words at reset settings (closed = low level)
  task automatic test_directed();
    send_word(bdpc_pkg::REQ_POLL, 1'b1, 48'd0);        // open, nothing happens
    send_word(bdpc_pkg::REQ_EDGE, 1'b1, 48'd0);        // edge at the level already seen
    send_word(bdpc_pkg::REQ_EDGE, 1'b0, 48'd100);      // goes closed
    send_word(bdpc_pkg::REQ_EDGE, 1'b1, 48'd150);      // bounce back, too short
    send_word(bdpc_pkg::REQ_EDGE, 1'b0, 48'd200);
    send_word(bdpc_pkg::REQ_EDGE, 1'b0, 48'd300);      // repeated edge, dropped
    send_word(bdpc_pkg::REQ_POLL, 1'b0, 48'd200);      // poll at a stale time
    send_word(bdpc_pkg::REQ_POLL, 1'b0, 48'd20200);    // exactly the debounce time
    send_word(bdpc_pkg::REQ_POLL, 1'b0, 48'd20201);    // one past: closed reported
    send_word(bdpc_pkg::REQ_POLL, 1'b0, 48'd1000200);  // long press at the threshold
    send_word(bdpc_pkg::REQ_POLL, 1'b0, 48'd2000199);  // just short of a repeat
    send_word(bdpc_pkg::REQ_POLL, 1'b0, 48'd2000200);  // held-repeat
    send_word(bdpc_pkg::REQ_EDGE, 1'b1, 48'd2000300);  // release after hold
    send_word(bdpc_pkg::REQ_POLL, 1'b1, 48'd2020301);
    send_word(bdpc_pkg::REQ_POLL, 1'b0, 48'd3000000);  // short press by polls only
    send_word(bdpc_pkg::REQ_POLL, 1'b0, 48'd3020001);
    send_word(bdpc_pkg::REQ_POLL, 1'b1, 48'd3100000);
    send_word(bdpc_pkg::REQ_POLL, 1'b1, 48'd3120001);
    send_word(bdpc_pkg::REQ_POLL, 1'b0, 48'd3100000);  // level differs but time is stale
    send_word(bdpc_pkg::REQ_EDGE, 1'b0, 48'd4000000);  // change found by the edge back
    send_word(bdpc_pkg::REQ_EDGE, 1'b1, 48'd4030000);
    send_word(bdpc_pkg::REQ_POLL, 1'b1, 48'd4060001);
    send_word(bdpc_pkg::REQ_POLL, 1'b0, 48'd5000000);
    send_word(bdpc_pkg::REQ_POLL, 1'b1, 48'd10);       // time going backwards
    send_word(bdpc_pkg::REQ_POLL, 1'b0, 48'd5020001);
    now_us = 48'd6000000;
  endtask

  task automatic test_default_config();
    run_phase(bdpc_pkg::DEBOUNCE_RST, bdpc_pkg::LONG_PRESS_RST, 1'b1, 190);
  endtask

  task automatic test_config_extremes();
    run_phase(24'd0, 24'd1, 1'b1, 190);
    run_phase(24'hFFFFFF, 24'hFFFFFF, 1'b0, 190);
    run_phase(24'd0, 24'hFFFFFF, 1'b0, 100);
  endtask

  task automatic test_random_config();
    run_phase(24'($urandom_range(0, 50000)), 24'($urandom_range(1, 3000000)),
              1'($urandom_range(0, 1)), 140);
    run_phase(24'($urandom_range(0, 300)), 24'($urandom_range(1, 2000)),
              1'($urandom_range(0, 1)), 140);
  endtask

  // timestamps at the top of the range
  task automatic test_time_top();
    settle();
    write_reg(bdpc_pkg::REG_DEBOUNCE, 24'd5);
    write_reg(bdpc_pkg::REG_LONG_PRESS, 24'd10);
    write_reg(bdpc_pkg::REG_CLOSED_HIGH, {{(bdpc_pkg::CFG_W-1){1'b0}}, 1'b1});
    n_settings++;
    now_us = 48'h7FFF_FFFF_FF00;
    send_state(bdpc_pkg::REQ_EDGE, 1'b1);
    step_time(3);
    send_state(bdpc_pkg::REQ_EDGE, 1'b0);
    step_time(10);
    send_state(bdpc_pkg::REQ_POLL, 1'b1);
    step_time(6);
    send_state(bdpc_pkg::REQ_POLL, 1'b1);
    now_us = TIME_TOP - 48'd40;
    send_state(bdpc_pkg::REQ_POLL, 1'b1);
    step_time(10);
    send_state(bdpc_pkg::REQ_POLL, 1'b1);
    step_time(20);
    send_state(bdpc_pkg::REQ_EDGE, 1'b0);
    step_time(10);
    send_state(bdpc_pkg::REQ_POLL, 1'b0);
    send_state(bdpc_pkg::REQ_POLL, 1'b1);
    send_state(bdpc_pkg::REQ_EDGE, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid     = 1'b0;
    in_if.req_type  = bdpc_pkg::REQ_EDGE;
    in_if.pin_level = 1'b0;
    in_if.time_us   = '0;
    out_if.ready    = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_default_config();
    test_config_extremes();
    test_random_config();
    test_time_top();
    settle();

    $display("sent %0d words under %0d register settings, checked %0d results",
             words_sent, n_settings + 1, results_seen);
    $display("seen: %0d debounced changes, %0d short, %0d long, %0d held-repeat",
             n_chg, n_short, n_long, n_held);
    if (mismatches == 0 && press_expect_q.size() == 0) begin
      $display("button_debounce_press_classifier_top: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("button_debounce_press_classifier_top: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/bdpc_pkg.sv
src/bdpc_in_if.sv
src/bdpc_out_if.sv
src/bdpc_cfg.sv
src/bdpc_core.sv
src/button_debounce_press_classifier_top.sv
test/tb.sv
